/* hw/rtl/midi_channel_message_tracker_macros.svh */
// Assertion macros shared by the tracker RTL.
// Needs clk_i and rst_ni in the scope of each use; empty under SYNTHESIS.
`ifndef MIDI_CHANNEL_MESSAGE_TRACKER_MACROS_SVH
`define MIDI_CHANNEL_MESSAGE_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define MCMT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mcmt: check failed");
`define MCMT_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mcmt: forbidden condition seen");
`else
`define MCMT_ASSERT(name, prop)
`define MCMT_ASSERT_NEVER(name, cond)
`endif
`endif

/* hw/rtl/mcmt_pkg.sv */
// Types and constants of the MIDI channel message tracker.
// No dependencies; imported by the controller, datapath and top level.
package mcmt_pkg;

  localparam int unsigned IN_W  = 48;
  localparam int unsigned OUT_W = 40;

  localparam logic [14:0] BEND_CENTER = 15'd8192;

  typedef enum logic [2:0] {
    CMD_MSG     = 3'd0,
    CMD_RD_CTRL = 3'd1,
    CMD_RD_NOTE = 3'd2,
    CMD_RD_BEND = 3'd3,
    CMD_RD_PRES = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    MT_NOTE_OFF  = 4'h8,
    MT_NOTE_ON   = 4'h9,
    MT_POLY_PRES = 4'hA,
    MT_CONTROL   = 4'hB,
    MT_PROGRAM   = 4'hC,
    MT_CHAN_PRES = 4'hD,
    MT_BEND      = 4'hE
  } msg_type_e;

  typedef enum logic [3:0] {
    EV_UNKNOWN   = 4'd0,
    EV_NOTE_OFF  = 4'd1,
    EV_NOTE_ON   = 4'd2,
    EV_POLY_PRES = 4'd3,
    EV_CONTROL   = 4'd4,
    EV_PROGRAM   = 4'd5,
    EV_CHAN_PRES = 4'd6,
    EV_BEND      = 4'd7,
    EV_COMMAND   = 4'd8
  } event_kind_e;

  typedef struct packed {
    logic take;
    logic rd_load;
    logic sweep;
  } ctl_t;

endpackage

/* hw/rtl/midi_channel_message_tracker.sv */
// MIDI channel message tracker: decodes one short message or command per beat into
// one result beat, and keeps per-channel note, controller, bend and pressure state.
// Items are taken one at a time. A message, a bend read, a pressure read, a clear
// or an unknown command is registered at acceptance, so its result shows in the
// next cycle; a note or controller read passes through the registered read port of
// its key store and then the result register. The next item is accepted once the
// result register is empty or being drained. After reset, and after each clear
// command, the note and controller stores are swept to zero one entry per cycle,
// all 2^(CH_W+KEY_W) entries (2048 with 16 channels and 128 keys), during which no
// item is accepted; the clear result itself can be taken during the sweep.
// Depends on mcmt_pkg, mcmt_ctrl and mcmt_dp.
module midi_channel_message_tracker #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned NUM_KEYS     = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // command[2:0], msg_status[10:3], msg_first_data[18:11],
  // msg_second_data[26:19], read_channel[34:27], read_index[42:35], zero fill
  input  logic [mcmt_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // event_kind[3:0], event_channel[8:4], event_first_data[16:9],
  // event_second_data[24:17], result_value[39:25]
  output logic [mcmt_pkg::OUT_W-1:0] m_tdata
);
  import mcmt_pkg::*;

  ctl_t        ctl;
  logic        sweep_last;
  logic [3:0]  event_kind;
  logic [4:0]  event_channel;
  logic [7:0]  event_first_data;
  logic [7:0]  event_second_data;
  logic [14:0] result_value;

  mcmt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid),
    .out_ready_i  (m_tready),
    .command_i    (s_tdata[2:0]),
    .sweep_last_i (sweep_last),
    .in_ready_o   (s_tready),
    .out_valid_o  (m_tvalid),
    .ctl_o        (ctl)
  );

  mcmt_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_KEYS     (NUM_KEYS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .command_i           (s_tdata[2:0]),
    .msg_status_i        (s_tdata[10:3]),
    .msg_first_data_i    (s_tdata[18:11]),
    .msg_second_data_i   (s_tdata[26:19]),
    .read_channel_i      (s_tdata[34:27]),
    .read_index_i        (s_tdata[42:35]),
    .sweep_last_o        (sweep_last),
    .event_kind_o        (event_kind),
    .event_channel_o     (event_channel),
    .event_first_data_o  (event_first_data),
    .event_second_data_o (event_second_data),
    .result_value_o      (result_value)
  );

  assign m_tdata = {result_value, event_second_data, event_first_data,
                    event_channel, event_kind};

endmodule

/* hw/rtl/mcmt_dp.sv */
// Datapath: event decode, the four per-channel stores and the result register.
// Depends on mcmt_pkg; driven by mcmt_ctrl through a ctl_t command group.
module mcmt_dp #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned NUM_KEYS     = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mcmt_pkg::ctl_t ctl_i,
  input  logic [2:0]    command_i,
  input  logic [7:0]    msg_status_i,
  input  logic [7:0]    msg_first_data_i,
  input  logic [7:0]    msg_second_data_i,
  input  logic [7:0]    read_channel_i,
  input  logic [7:0]    read_index_i,
  output logic          sweep_last_o,
  output logic [3:0]    event_kind_o,
  output logic [4:0]    event_channel_o,
  output logic [7:0]    event_first_data_o,
  output logic [7:0]    event_second_data_o,
  output logic [14:0]   result_value_o
);
  import mcmt_pkg::*;

  localparam int unsigned CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned ADDR_W = CH_W + KEY_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  logic [7:0]        note_mem [DEPTH];
  logic [7:0]        ctrl_mem [DEPTH];
  logic [7:0]        note_rdata_q;
  logic [7:0]        ctrl_rdata_q;
  logic [14:0]       bend_q   [NUM_CHANNELS];
  logic [7:0]        pres_q   [NUM_CHANNELS];
  logic [ADDR_W-1:0] sweep_cnt_q;

  logic [3:0]        kind_q;
  logic [4:0]        chan_q;
  logic [7:0]        f1_q;
  logic [7:0]        f2_q;
  logic [14:0]       val_q;
  logic              rd_ok_q;
  logic              rd_ctrl_q;

  logic [3:0]        msg_type;
  logic [3:0]        ch_nib;
  logic [CH_W-1:0]   wch;
  logic [KEY_W-1:0]  wkey;
  logic              key_ok;
  logic              rch_ok;
  logic              rix_ok;
  logic [7:0]        rch_m1;
  logic [CH_W-1:0]   rch_idx;
  logic              is_msg;
  logic              note_we;
  logic              ctrl_we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        note_wdata;
  logic [7:0]        ctrl_wdata;
  logic [3:0]        kind_d;
  logic [4:0]        chan_d;
  logic [7:0]        f1_d;
  logic [7:0]        f2_d;
  logic [14:0]       val_d;

  always_comb begin
    msg_type = msg_status_i[7:4];
    ch_nib   = msg_status_i[3:0];
    if (ch_nib > 4'(NUM_CHANNELS - 1)) begin
      wch = CH_W'(NUM_CHANNELS - 1);
    end else begin
      wch = ch_nib[CH_W-1:0];
    end
    key_ok  = msg_first_data_i < 8'(NUM_KEYS);
    wkey    = msg_first_data_i[KEY_W-1:0];
    rch_ok  = (read_channel_i != 8'd0) && (read_channel_i <= 8'(NUM_CHANNELS));
    rix_ok  = read_index_i < 8'(NUM_KEYS);
    rch_m1  = read_channel_i - 8'd1;
    rch_idx = rch_m1[CH_W-1:0];
    is_msg  = ctl_i.take && (command_i == CMD_MSG);
  end

  always_comb begin
    note_we    = ctl_i.sweep || (is_msg && key_ok &&
                 (msg_type == MT_NOTE_OFF || msg_type == MT_NOTE_ON));
    ctrl_we    = ctl_i.sweep || (is_msg && key_ok && msg_type == MT_CONTROL);
    waddr      = ctl_i.sweep ? sweep_cnt_q : {wch, wkey};
    raddr      = {rch_idx, read_index_i[KEY_W-1:0]};
    note_wdata = (!ctl_i.sweep && msg_type == MT_NOTE_ON) ? msg_second_data_i : 8'd0;
    ctrl_wdata = ctl_i.sweep ? 8'd0 : msg_second_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (note_we) begin
      note_mem[waddr] <= note_wdata;
    end
    note_rdata_q <= note_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_we) begin
      ctrl_mem[waddr] <= ctrl_wdata;
    end
    ctrl_rdata_q <= ctrl_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (ctl_i.sweep) begin
      sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
    end
  end

  assign sweep_last_o = &sweep_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        bend_q[i] <= BEND_CENTER;
        pres_q[i] <= 8'd0;
      end
    end else if (ctl_i.take && command_i == CMD_CLEAR) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        bend_q[i] <= BEND_CENTER;
        pres_q[i] <= 8'd0;
      end
    end else if (is_msg && msg_type == MT_BEND) begin
      bend_q[wch] <= {msg_second_data_i, msg_first_data_i[6:0]};
    end else if (is_msg && msg_type == MT_CHAN_PRES) begin
      pres_q[wch] <= msg_first_data_i;
    end
  end

  always_comb begin
    kind_d = EV_COMMAND;
    chan_d = 5'd0;
    f1_d   = 8'd0;
    f2_d   = 8'd0;
    val_d  = 15'd0;
    case (command_i)
      CMD_MSG: begin
        chan_d = {1'b0, ch_nib} + 5'd1;
        f1_d   = msg_first_data_i;
        f2_d   = msg_second_data_i;
        case (msg_type)
          MT_NOTE_OFF: kind_d = EV_NOTE_OFF;
          MT_NOTE_ON: begin
            if (msg_second_data_i == 8'd0) begin
              kind_d = EV_NOTE_OFF;
            end else begin
              kind_d = EV_NOTE_ON;
              val_d  = {7'd0, msg_second_data_i};
            end
          end
          MT_POLY_PRES: begin
            kind_d = EV_POLY_PRES;
            val_d  = {7'd0, msg_second_data_i};
          end
          MT_CONTROL: begin
            kind_d = EV_CONTROL;
            val_d  = {7'd0, msg_second_data_i};
          end
          MT_PROGRAM: begin
            kind_d = EV_PROGRAM;
            val_d  = {7'd0, msg_first_data_i};
          end
          MT_CHAN_PRES: begin
            kind_d = EV_CHAN_PRES;
            val_d  = {7'd0, msg_first_data_i};
          end
          MT_BEND: begin
            kind_d = EV_BEND;
            val_d  = {msg_second_data_i, msg_first_data_i[6:0]};
          end
          default: kind_d = EV_UNKNOWN;
        endcase
      end
      CMD_RD_BEND: val_d = rch_ok ? bend_q[rch_idx] : BEND_CENTER;
      CMD_RD_PRES: val_d = rch_ok ? {7'd0, pres_q[rch_idx]} : 15'd0;
      default: val_d = 15'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      kind_q    <= kind_d;
      chan_q    <= chan_d;
      f1_q      <= f1_d;
      f2_q      <= f2_d;
      val_q     <= val_d;
      rd_ok_q   <= rch_ok && rix_ok;
      rd_ctrl_q <= command_i == CMD_RD_CTRL;
    end else if (ctl_i.rd_load) begin
      // pick up the registered store word
      if (!rd_ok_q) begin
        val_q <= 15'd0;
      end else if (rd_ctrl_q) begin
        val_q <= {7'd0, ctrl_rdata_q};
      end else begin
        val_q <= {7'd0, note_rdata_q};
      end
    end
  end

  assign event_kind_o        = kind_q;
  assign event_channel_o     = chan_q;
  assign event_first_data_o  = f1_q;
  assign event_second_data_o = f2_q;
  assign result_value_o      = val_q;

endmodule

/* hw/rtl/mcmt_ctrl.sv */
// Controller: sequences accept, store read, clearing sweep and result hand-off.
// Depends on mcmt_pkg and midi_channel_message_tracker_macros.svh.
`include "midi_channel_message_tracker_macros.svh"
module mcmt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_ready_i,
  input  logic [2:0]     command_i,
  input  logic           sweep_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output mcmt_pkg::ctl_t ctl_o
);
  import mcmt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CLR
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   rd_mem;

  assign rd_mem      = (command_i == CMD_RD_CTRL) || (command_i == CMD_RD_NOTE);
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o.take    = in_fire;
    ctl_o.rd_load = state_q == ST_RD;
    ctl_o.sweep   = state_q == ST_CLR;
  end

  // reset starts with a full clearing sweep of the key stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      if ((in_fire && !rd_mem) || state_q == ST_RD) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && rd_mem) begin
            state_q <= ST_RD;
          end else if (in_fire && command_i == CMD_CLEAR) begin
            state_q <= ST_CLR;
          end
        end
        ST_RD: state_q <= ST_IDLE;
        ST_CLR: begin
          if (sweep_last_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `MCMT_ASSERT(a_rd_then_result, state_q == ST_RD |=> state_q == ST_IDLE && out_valid_q)
  `MCMT_ASSERT(a_rd_follows_take, in_fire && rd_mem |=> state_q == ST_RD)
  `MCMT_ASSERT(a_hold_result, out_valid_q && !out_ready_i |=> out_valid_q)
  `MCMT_ASSERT_NEVER(a_take_while_busy, in_fire && state_q != ST_IDLE)
  `MCMT_ASSERT(a_clear_sweeps, in_fire && command_i == CMD_CLEAR |=> state_q == ST_CLR)

endmodule

/* verif/midi_channel_message_tracker_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for midi_channel_message_tracker: a directed table, then
// random messages, reads and commands with random idling on both streams, checked against a
// behavioural tracker of the four channel stores. Depends on mcmt_pkg and the RTL.
module midi_channel_message_tracker_tb;
  import mcmt_pkg::*;

  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned NUM_KEYS     = 128;
  localparam int unsigned RAND_BEATS   = 925;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned DIR_ROWS     = 27;
  localparam int unsigned EXP_DEPTH    = 64;

  localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
  localparam logic [3:0] MT_UNDEF     = 4'h0;
  localparam logic [3:0] MT_SYSTEM    = 4'hF;

  typedef struct packed {
    logic [4:0] fill;
    logic [7:0] read_index;
    logic [7:0] read_channel;
    logic [7:0] second;
    logic [7:0] first;
    logic [7:0] status;
    logic [2:0] command;
  } tracker_item_t;

  typedef struct packed {
    logic [14:0] value;
    logic [7:0]  second;
    logic [7:0]  first;
    logic [4:0]  channel;
    logic [3:0]  kind;
  } event_beat_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  status;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [7:0]  rch;
    logic [7:0]  rix;
    logic        typed;
    logic [3:0]  kind;
    logic [4:0]  chan;
    logic [7:0]  f1;
    logic [7:0]  f2;
    logic [14:0] val;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;

  logic [7:0]  note_velocity [NUM_CHANNELS][NUM_KEYS];
  logic [7:0]  controller_value [NUM_CHANNELS][NUM_KEYS];
  logic [14:0] bend_value [NUM_CHANNELS];
  logic [7:0]  channel_pressure [NUM_CHANNELS];

  event_beat_t expected_fifo [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  int unsigned recv_cnt;

  directed_row_t directed_tab [DIR_ROWS] = '{
    '{CMD_RD_BEND, 8'h00, 8'h00, 8'h00, 8'd1, 8'd0, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      BEND_CENTER},
    '{CMD_RD_NOTE, 8'h00, 8'h00, 8'h00, 8'd1, 8'd0, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      15'd0},
    '{CMD_RD_CTRL, 8'h00, 8'h00, 8'h00, 8'd16, 8'd127, 1'b1, EV_COMMAND, 5'd0, 8'h00,
      8'h00, 15'd0},
    '{CMD_RD_PRES, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      15'd0},
    '{CMD_RD_BEND, 8'hFF, 8'hFF, 8'hFF, 8'd255, 8'd255, 1'b1, EV_COMMAND, 5'd0, 8'h00,
      8'h00, BEND_CENTER},
    '{CMD_MSG, {MT_NOTE_ON, 4'h0}, 8'd60, 8'd100, 8'd0, 8'd0, 1'b0, EV_UNKNOWN, 5'd0,
      8'h00, 8'h00, 15'd0},
    '{CMD_RD_NOTE, 8'h00, 8'h00, 8'h00, 8'd1, 8'd60, 1'b0, EV_UNKNOWN, 5'd0, 8'h00, 8'h00,
      15'd0},
    '{CMD_MSG, {MT_NOTE_ON, 4'hF}, 8'd127, 8'd0, 8'd0, 8'd0, 1'b1, EV_NOTE_OFF, 5'd16,
      8'd127, 8'd0, 15'd0},
    '{CMD_MSG, {MT_NOTE_OFF, 4'h0}, 8'd60, 8'd64, 8'd0, 8'd0, 1'b0, EV_UNKNOWN, 5'd0,
      8'h00, 8'h00, 15'd0},
    '{CMD_MSG, {MT_NOTE_ON, 4'h1}, 8'd200, 8'd127, 8'd0, 8'd0, 1'b0, EV_UNKNOWN, 5'd0,
      8'h00, 8'h00, 15'd0},
    '{CMD_MSG, {MT_POLY_PRES, 4'h3}, 8'd5, 8'd255, 8'd0, 8'd0, 1'b0, EV_UNKNOWN, 5'd0,
      8'h00, 8'h00, 15'd0},
    '{CMD_MSG, {MT_CONTROL, 4'h0}, 8'd7, 8'd255, 8'd0, 8'd0, 1'b0, EV_UNKNOWN, 5'd0,
      8'h00, 8'h00, 15'd0},
    '{CMD_MSG, {MT_CONTROL, 4'hF}, 8'd255, 8'd1, 8'd0, 8'd0, 1'b0, EV_UNKNOWN, 5'd0,
      8'h00, 8'h00, 15'd0},
    '{CMD_RD_CTRL, 8'h00, 8'h00, 8'h00, 8'd1, 8'd7, 1'b0, EV_UNKNOWN, 5'd0, 8'h00, 8'h00,
      15'd0},
    '{CMD_RD_CTRL, 8'h00, 8'h00, 8'h00, 8'd1, 8'd128, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      15'd0},
    '{CMD_MSG, {MT_PROGRAM, 4'h5}, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, EV_UNKNOWN, 5'd0,
      8'h00, 8'h00, 15'd0},
    '{CMD_MSG, {MT_CHAN_PRES, 4'h2}, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, EV_UNKNOWN, 5'd0,
      8'h00, 8'h00, 15'd0},
    '{CMD_RD_PRES, 8'h00, 8'h00, 8'h00, 8'd3, 8'd0, 1'b0, EV_UNKNOWN, 5'd0, 8'h00, 8'h00,
      15'd0},
    '{CMD_MSG, {MT_BEND, 4'hF}, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, EV_BEND, 5'd16, 8'd255,
      8'd255, 15'h7FFF},
    '{CMD_RD_BEND, 8'h00, 8'h00, 8'h00, 8'd16, 8'd0, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      15'h7FFF},
    '{CMD_MSG, {MT_UNDEF, 4'h0}, 8'hAA, 8'h55, 8'd0, 8'd0, 1'b1, EV_UNKNOWN, 5'd1, 8'hAA,
      8'h55, 15'd0},
    '{CMD_MSG, {MT_SYSTEM, 4'h0}, 8'h12, 8'h34, 8'd0, 8'd0, 1'b0, EV_UNKNOWN, 5'd0,
      8'h00, 8'h00, 15'd0},
    '{CMD_UNDEF_LO, 8'hFF, 8'hFF, 8'hFF, 8'd1, 8'd1, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      15'd0},
    '{CMD_UNDEF_HI, 8'h9F, 8'h01, 8'h7F, 8'd16, 8'd0, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      15'd0},
    '{CMD_CLEAR, 8'hE0, 8'h11, 8'h22, 8'd2, 8'd3, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      15'd0},
    '{CMD_RD_BEND, 8'h00, 8'h00, 8'h00, 8'd16, 8'd0, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      BEND_CENTER},
    '{CMD_RD_CTRL, 8'h00, 8'h00, 8'h00, 8'd1, 8'd7, 1'b1, EV_COMMAND, 5'd0, 8'h00, 8'h00,
      15'd0}
  };

  midi_channel_message_tracker #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .NUM_KEYS    (NUM_KEYS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  function automatic void sweep_stores();
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        note_velocity[c][k]    = 8'd0;
        controller_value[c][k] = 8'd0;
      end
      bend_value[c]       = BEND_CENTER;
      channel_pressure[c] = 8'd0;
    end
  endfunction

  function automatic event_beat_t track_message(tracker_item_t it);
    event_beat_t ev;
    logic [3:0]  ci;
    bit          key_ok;
    bit          chan_ok;
    ev      = '0;
    ev.kind = EV_COMMAND;
    ci      = it.status[3:0];
    key_ok  = it.first < NUM_KEYS;
    chan_ok = it.read_channel >= 1 && it.read_channel <= NUM_CHANNELS;
    case (it.command)
      CMD_MSG: begin
        ev.channel = {1'b0, ci} + 5'd1;
        ev.first   = it.first;
        ev.second  = it.second;
        case (it.status[7:4])
          MT_NOTE_OFF: begin
            ev.kind = EV_NOTE_OFF;
            if (key_ok) note_velocity[ci][it.first[6:0]] = 8'd0;
          end
          MT_NOTE_ON: begin
            if (it.second == 8'd0) begin
              ev.kind = EV_NOTE_OFF;
            end else begin
              ev.kind  = EV_NOTE_ON;
              ev.value = {7'd0, it.second};
            end
            if (key_ok) note_velocity[ci][it.first[6:0]] = ev.value[7:0];
          end
          MT_POLY_PRES: begin
            ev.kind  = EV_POLY_PRES;
            ev.value = {7'd0, it.second};
          end
          MT_CONTROL: begin
            ev.kind  = EV_CONTROL;
            ev.value = {7'd0, it.second};
            if (key_ok) controller_value[ci][it.first[6:0]] = it.second;
          end
          MT_PROGRAM: begin
            ev.kind  = EV_PROGRAM;
            ev.value = {7'd0, it.first};
          end
          MT_CHAN_PRES: begin
            ev.kind              = EV_CHAN_PRES;
            ev.value             = {7'd0, it.first};
            channel_pressure[ci] = it.first;
          end
          MT_BEND: begin
            ev.kind        = EV_BEND;
            ev.value       = {it.second, it.first[6:0]};
            bend_value[ci] = ev.value;
          end
          default: begin
            ev.kind = EV_UNKNOWN;
          end
        endcase
      end
      CMD_RD_CTRL, CMD_RD_NOTE: begin
        if (chan_ok && it.read_index < NUM_KEYS) begin
          if (it.command == CMD_RD_CTRL)
            ev.value = {7'd0, controller_value[it.read_channel - 1][it.read_index[6:0]]};
          else
            ev.value = {7'd0, note_velocity[it.read_channel - 1][it.read_index[6:0]]};
        end
      end
      CMD_RD_BEND: begin
        ev.value = chan_ok ? bend_value[it.read_channel - 1] : BEND_CENTER;
      end
      CMD_RD_PRES: begin
        if (chan_ok) ev.value = {7'd0, channel_pressure[it.read_channel - 1]};
      end
      CMD_CLEAR: begin
        sweep_stores();
      end
      default: begin
      end
    endcase
    return ev;
  endfunction

  function automatic tracker_item_t random_message();
    tracker_item_t it;
    int unsigned   pick;
    bit            focus;
    logic [3:0]    mtype;
    it                 = '0;
    pick               = $urandom_range(0, 199);
    focus              = 1'($urandom_range(0, 1));
    it.status          = 8'($urandom_range(0, 255));
    it.first           = 8'($urandom_range(0, 255));
    it.second          = 8'($urandom_range(0, 255));
    it.read_channel    = 8'($urandom_range(0, 255));
    it.read_index      = 8'($urandom_range(0, 255));
    if (pick < 120) begin
      it.command = CMD_MSG;
      mtype = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(8, 14));
      it.status = {mtype, focus ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15))};
      if (focus)
        it.first = 8'($urandom_range(60, 67));
      else if ($urandom_range(0, 4) != 0)
        it.first = 8'($urandom_range(0, 127));
      if ($urandom_range(0, 5) == 0)
        it.second = 8'd0;
      else if ($urandom_range(0, 3) != 0)
        it.second = 8'($urandom_range(0, 127));
    end else if (pick < 192) begin
      it.command = 3'($urandom_range(CMD_RD_CTRL, CMD_RD_PRES));
      if (focus) begin
        it.read_channel = 8'($urandom_range(1, 4));
        it.read_index   = 8'($urandom_range(60, 67));
      end else begin
        if ($urandom_range(0, 9) != 0) it.read_channel = 8'($urandom_range(1, NUM_CHANNELS));
        if ($urandom_range(0, 4) != 0) it.read_index = 8'($urandom_range(0, NUM_KEYS - 1));
      end
    end else if (pick < 199) begin
      it.command = $urandom_range(0, 1) ? CMD_UNDEF_LO : CMD_UNDEF_HI;
    end else begin
      it.command = CMD_CLEAR;
    end
    return it;
  endfunction

  task automatic send_beat(tracker_item_t it, bit typed, event_beat_t typed_ev);
    int unsigned gap;
    event_beat_t ev;
    gap = ((sent_cnt / 60) % 4 == 1) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    do @(posedge clk_i); while (!s_tready);
    ev = track_message(it);
    expected_fifo[exp_wr % EXP_DEPTH] = typed ? typed_ev : ev;
    exp_wr++;
    sent_cnt++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // drain results with random back-pressure
  initial begin
    int unsigned stall;
    event_beat_t act;
    event_beat_t exp;
    m_tready = 1'b0;
    recv_cnt = 0;
    forever begin
      stall = ((recv_cnt / 45) % 4 == 2) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        @(negedge clk_i);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && rst_ni));
      act = m_tdata;
      recv_cnt++;
      if (exp_wr == exp_rd) begin
        error_cnt++;
        $display("%0t: unexpected beat kind=%0d chan=%0d d1=%0h d2=%0h value=%0d",
                 $time, act.kind, act.channel, act.first, act.second, act.value);
      end else begin
        exp = expected_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (act !== exp) begin
          error_cnt++;
          $display("%0t: expected kind=%0d chan=%0d d1=%0h d2=%0h value=%0d",
                   $time, exp.kind, exp.channel, exp.first, exp.second, exp.value);
          $display("%0t: actual   kind=%0d chan=%0d d1=%0h d2=%0h value=%0d",
                   $time, act.kind, act.channel, act.first, act.second, act.value);
        end
      end
    end
  end

  initial begin
    tracker_item_t it;
    event_beat_t   ev;
    error_cnt = 0;
    sent_cnt  = 0;
    exp_wr    = 0;
    exp_rd    = 0;
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    sweep_stores();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_tab[i]) begin
      it              = '0;
      it.command      = directed_tab[i].command;
      it.status       = directed_tab[i].status;
      it.first        = directed_tab[i].first;
      it.second       = directed_tab[i].second;
      it.read_channel = directed_tab[i].rch;
      it.read_index   = directed_tab[i].rix;
      ev              = '{directed_tab[i].val, directed_tab[i].f2, directed_tab[i].f1,
                          directed_tab[i].chan, directed_tab[i].kind};
      send_beat(it, directed_tab[i].typed, ev);
    end

    repeat (RAND_BEATS) send_beat(random_message(), 1'b0, '0);

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
